### design/brq_pkg.sv
// brq_pkg: types and constants for the button release event queue
// no dependencies; imported by brq_state, brq_qctrl, the top level and the bench

package brq_pkg;

    localparam int BTN_W = 14;
    localparam int BYTE_B_USED = 6;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_POLL   = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [7:0]        button_byte_a;
        logic [7:0]        button_byte_b;
        logic signed [7:0] stick_x_in;
        logic signed [7:0] stick_y_in;
    } t_in_item;

    typedef struct packed {
        logic [BTN_W-1:0]  held_buttons;
        logic signed [7:0] stick_x_now;
        logic signed [7:0] stick_y_now;
        logic [BTN_W-1:0]  released_buttons;
    } t_out_item;

    // request from the pipeline to the queue control
    typedef struct packed {
        logic             push_req;
        logic             pop_req;
        logic [BTN_W-1:0] mask;
    } t_q_cmd;

    // queue status back to the pipeline
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

### design/brq_ram.sv
// brq_ram: generic single write port, single read port ram with registered read
// no dependencies

module brq_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/brq_state.sv
// brq_state: held button mask and stick registers, release mask of a sample
// depends on brq_pkg

module brq_state import brq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sample_go,
    input  t_in_item          i_item,
    output logic [BTN_W-1:0]  o_held,
    output logic signed [7:0] o_stick_x,
    output logic signed [7:0] o_stick_y,
    output logic [BTN_W-1:0]  o_release
);

    logic [BTN_W-1:0]  r_held, n_held;
    logic signed [7:0] r_stick_x, n_stick_x;
    logic signed [7:0] r_stick_y, n_stick_y;
    logic [BTN_W-1:0]  now_mask;

    assign now_mask  = {i_item.button_byte_b[BYTE_B_USED-1:0], i_item.button_byte_a};
    // held before and not held now
    assign o_release = r_held & ~now_mask;

    always_comb begin
        n_held    = r_held;
        n_stick_x = r_stick_x;
        n_stick_y = r_stick_y;
        if (i_sample_go) begin
            n_held    = now_mask;
            n_stick_x = i_item.stick_x_in;
            n_stick_y = i_item.stick_y_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_stick_x <= '0;
            r_stick_y <= '0;
        end else begin
            r_held    <= n_held;
            r_stick_x <= n_stick_x;
            r_stick_y <= n_stick_y;
        end
    end

    assign o_held    = r_held;
    assign o_stick_x = r_stick_x;
    assign o_stick_y = r_stick_y;

endmodule

### design/brq_qctrl.sv
// brq_qctrl: event queue pointers, fill count and duplicate filter over brq_ram
// depends on brq_pkg and brq_ram

module brq_qctrl import brq_pkg::*; #(
    parameter int QUEUE_DEPTH = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_q_cmd           i_cmd,
    output t_q_stat          o_stat,
    output logic [BTN_W-1:0] o_rdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(QUEUE_DEPTH - 1);

    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_count, n_count;
    logic [BTN_W-1:0] r_last, n_last;
    logic             empty, full, do_push, do_pop;

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] ptr);
        next_ptr = (ptr == LAST_ADDR) ? '0 : ptr + 1'b1;
    endfunction

    assign empty   = (r_count == '0);
    assign full    = (r_count == FULL_COUNT);
    // skip the push only when the newest queued entry already matches
    assign do_push = i_cmd.push_req && !(!empty && i_cmd.mask == r_last);
    assign do_pop  = i_cmd.pop_req && !empty;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_last  = r_last;
        if (do_push) begin
            n_tail = next_ptr(r_tail);
            n_last = i_cmd.mask;
            if (full) begin
                n_head = next_ptr(r_head);
            end else begin
                n_count = r_count + 1'b1;
            end
        end else if (do_pop) begin
            n_head  = next_ptr(r_head);
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_last  <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_last  <= n_last;
        end
    end

    brq_ram #(
        .WIDTH (BTN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (r_tail),
        .i_wdata (i_cmd.mask),
        .i_re    (do_pop),
        .i_raddr (r_head),
        .o_rdata (o_rdata)
    );

    assign o_stat.empty = empty;
    assign o_stat.full  = full;

endmodule

### design/button_release_event_queue.sv
// button_release_event_queue: top level, two-stage result pipeline around state and queue
// poll path: a poll's result is registered in stage a, then in the output register, stage b; a sample gives none
// throughput: one item per cycle while the output is not stalled; each item makes at most one ram access
// reset: synchronous active-low reset clears held state, sticks, pointers and count
// the queue ram is not cleared; only written entries are ever read, so no clearing pass
// depends on brq_pkg, brq_state, brq_qctrl and brq_ram

module button_release_event_queue import brq_pkg::*; #(
    parameter int QUEUE_DEPTH = 2048
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    // result channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    // handshake and command decode
    logic in_go, sample_go, poll_go, a_move;

    // held state and sticks before this item
    logic [BTN_W-1:0]  held;
    logic signed [7:0] stick_x, stick_y;
    logic [BTN_W-1:0]  release_mask;

    // queue interface
    t_q_cmd           q_cmd;
    t_q_stat          q_stat;
    logic [BTN_W-1:0] q_rdata;

    // stage a: poll captured, ram read in flight
    logic              r_a_valid, n_a_valid;
    logic [BTN_W-1:0]  r_a_held, n_a_held;
    logic signed [7:0] r_a_stick_x, n_a_stick_x;
    logic signed [7:0] r_a_stick_y, n_a_stick_y;
    logic              r_a_empty, n_a_empty;

    // stage b: output register
    logic      r_b_valid, n_b_valid;
    t_out_item r_b_item, n_b_item;

    // stage a drains when the output register is free or being taken
    assign a_move     = !r_b_valid || !i_out_stall;
    assign o_in_stall = r_a_valid && !a_move;
    assign in_go      = i_in_valid && !o_in_stall;
    assign sample_go  = in_go && (i_in.cmd == CMD_SAMPLE);
    assign poll_go    = in_go && (i_in.cmd == CMD_POLL);

    brq_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_go (sample_go),
        .i_item      (i_in),
        .o_held      (held),
        .o_stick_x   (stick_x),
        .o_stick_y   (stick_y),
        .o_release   (release_mask)
    );

    assign q_cmd.push_req = sample_go;
    assign q_cmd.pop_req  = poll_go;
    assign q_cmd.mask     = release_mask;

    brq_qctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_qctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_cmd),
        .o_stat  (q_stat),
        .o_rdata (q_rdata)
    );

    always_comb begin
        n_a_valid   = r_a_valid;
        n_a_held    = r_a_held;
        n_a_stick_x = r_a_stick_x;
        n_a_stick_y = r_a_stick_y;
        n_a_empty   = r_a_empty;
        n_b_valid   = r_b_valid;
        n_b_item    = r_b_item;

        // stage a to stage b; ram data sits on q_rdata while stage a holds
        if (a_move) begin
            n_b_valid = r_a_valid;
            n_a_valid = 1'b0;
            if (r_a_valid) begin
                n_b_item.held_buttons     = r_a_held;
                n_b_item.stick_x_now      = r_a_stick_x;
                n_b_item.stick_y_now      = r_a_stick_y;
                n_b_item.released_buttons = r_a_empty ? '0 : q_rdata;
            end
        end

        // new poll enters stage a; an empty queue reports no release
        if (poll_go) begin
            n_a_valid   = 1'b1;
            n_a_held    = held;
            n_a_stick_x = stick_x;
            n_a_stick_y = stick_y;
            n_a_empty   = q_stat.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
        end
        // payload needs no reset
        r_a_held    <= n_a_held;
        r_a_stick_x <= n_a_stick_x;
        r_a_stick_y <= n_a_stick_y;
        r_a_empty   <= n_a_empty;
        r_b_item    <= n_b_item;
    end

    assign o_out_valid = r_b_valid;
    assign o_out       = r_b_item;

`ifndef SYNTHESIS
    // empty and full never coexist for a depth of at least two
    a_empty_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("queue reports empty and full together");

    // a sample into an empty queue always leaves one entry
    a_push_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sample_go && q_stat.empty) |=> !q_stat.empty)
        else $error("sample into empty queue did not push");

    // with both stages full and output stalled, no new item may enter
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_b_valid && i_out_stall) |-> o_in_stall)
        else $error("item accepted while pipeline is full");
`endif

endmodule

### tb/tb_top.sv
// tb_top: self-checking bench for button_release_event_queue
// depends on brq_pkg and the block's rtl; keeps its own shadow of held state and release fifo

module tb_top;
    import brq_pkg::*;

    localparam int QDEPTH       = 2048;
    localparam int RST_CYCLES   = 12;
    localparam int QUIET_TAIL   = 200;     // last items run with no idling on either side
    localparam int SETTLE_CYC   = 16;      // margin after all polls are answered, leave plenty
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 10;

    // one stimulus entry: the item plus a flag to hold it back until all polls are answered
    typedef struct packed {
        t_in_item item;
        logic     hold;
    } t_stim;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // shadow of the block state
    logic [BTN_W-1:0] held_mask   = '0;
    logic [7:0]       stick_x_now = '0;
    logic [7:0]       stick_y_now = '0;
    logic [BTN_W-1:0] newest_rel  = '0;
    logic [BTN_W-1:0] release_fifo[$];

    t_stim     stim_q[$];
    t_out_item polls_due[$];

    int src_gap   = 0;
    int sink_gap  = 0;
    int fail_cnt  = 0;
    int cycle_cnt = 0;

    button_release_event_queue #(
        .QUEUE_DEPTH(QDEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item)
    );

    always #2 clk = ~clk;

    // cycle guard, ends a hung run
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic log_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("[%0d] mismatch: %s", cycle_cnt, msg);
    endtask

    // shadow of one accepted item: samples update state and the release fifo,
    // polls produce the result the block must return
    task automatic advance_button_state(input t_in_item it);
        logic [BTN_W-1:0] now_mask;
        logic [BTN_W-1:0] rel;
        t_out_item        res;
        if (it.cmd == CMD_SAMPLE) begin
            // bits 7:6 of the second byte are not buttons
            now_mask    = {it.button_byte_b[BYTE_B_USED-1:0], it.button_byte_a};
            rel         = held_mask & ~now_mask;
            held_mask   = now_mask;
            stick_x_now = it.stick_x_in;
            stick_y_now = it.stick_y_in;
            // repeat of the newest queued mask is skipped, but only while the fifo holds one
            if (!(release_fifo.size() != 0 && rel == newest_rel)) begin
                // full fifo drops its oldest mask to make room
                if (release_fifo.size() >= QDEPTH)
                    void'(release_fifo.pop_front());
                release_fifo.push_back(rel);
                newest_rel = rel;
            end
        end else begin
            res.held_buttons     = held_mask;
            res.stick_x_now      = stick_x_now;
            res.stick_y_now      = stick_y_now;
            // empty fifo answers with zero
            res.released_buttons = (release_fifo.size() != 0) ? release_fifo.pop_front() : '0;
            polls_due.push_back(res);
        end
    endtask

    task automatic add_sample(input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] x, input logic [7:0] y,
                              input logic hold = 1'b0);
        t_stim s;
        s.item.cmd           = CMD_SAMPLE;
        s.item.button_byte_a = a;
        s.item.button_byte_b = b;
        s.item.stick_x_in    = x;
        s.item.stick_y_in    = y;
        s.hold               = hold;
        stim_q.push_back(s);
    endtask

    // poll payload bytes are don't-care, fill them with noise
    task automatic add_poll(input logic hold = 1'b0);
        t_stim s;
        s.item.cmd           = CMD_POLL;
        s.item.button_byte_a = 8'($urandom);
        s.item.button_byte_b = 8'($urandom);
        s.item.stick_x_in    = 8'($urandom);
        s.item.stick_y_in    = 8'($urandom);
        s.hold               = hold;
        stim_q.push_back(s);
    endtask

    function automatic logic [7:0] pick_stick();
        case ($urandom_range(0, 11))
            0:       return 8'h80;   // most negative
            1:       return 8'h7f;   // most positive
            2:       return 8'hff;
            3:       return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    // input driver: presents the next queued item, holds it while stalled,
    // inserts random gaps between items
    always @(posedge clk) begin
        logic     nxt_valid;
        t_in_item nxt_item;
        nxt_valid = in_valid;
        nxt_item  = in_item;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                advance_button_state(in_item);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (stim_q.size() > 0 &&
                             !(stim_q[0].hold && polls_due.size() > 0)) begin
                    // a held item waits for every outstanding poll to come back
                    nxt_valid = 1'b1;
                    nxt_item  = stim_q[0].item;
                    void'(stim_q.pop_front());
                    if (stim_q.size() > QUIET_TAIL && $urandom_range(0, 11) == 0)
                        src_gap = $urandom_range(1, 18);
                end
            end
        end else begin
            nxt_valid = 1'b0;
        end
        in_valid <= nxt_valid;
        in_item  <= nxt_item;
    end

    // result monitor and stall generator
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (polls_due.size() == 0) begin
                    log_failure($sformatf("result with no poll pending: held %h rel %h",
                                          out_item.held_buttons, out_item.released_buttons));
                end else begin
                    want = polls_due.pop_front();
                    if (out_item.held_buttons !== want.held_buttons ||
                        out_item.stick_x_now !== want.stick_x_now ||
                        out_item.stick_y_now !== want.stick_y_now ||
                        out_item.released_buttons !== want.released_buttons)
                        log_failure($sformatf(
                            "exp held %h x %h y %h rel %h, got held %h x %h y %h rel %h",
                            want.held_buttons, want.stick_x_now, want.stick_y_now,
                            want.released_buttons, out_item.held_buttons,
                            out_item.stick_x_now, out_item.stick_y_now,
                            out_item.released_buttons));
                end
            end
            // random stall bursts, none in the tail
            if (sink_gap > 0) begin
                sink_gap--;
                out_stall <= 1'b1;
            end else if (stim_q.size() > QUIET_TAIL && $urandom_range(0, 11) == 0) begin
                sink_gap = $urandom_range(1, 18) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int         n;
        int         roll;
        logic [7:0] keep_a;
        logic [7:0] keep_b;

        // directed: reset state, zero-mask push on empty fifo, repeat skip,
        // ignored top bits, stick extremes, polls down to an empty fifo
        add_poll();
        add_sample(8'h00, 8'h00, 8'h00, 8'h00);
        add_sample(8'hff, 8'hff, 8'h7f, 8'h80);
        add_poll();
        add_poll();
        add_sample(8'h00, 8'hc0, 8'h80, 8'h7f);
        add_sample(8'h00, 8'hc0, 8'h80, 8'h7f);
        add_sample(8'h00, 8'hc0, 8'hff, 8'h01);
        add_sample(8'haa, 8'h15, 8'hff, 8'h01);
        add_sample(8'h00, 8'h00, 8'h01, 8'hff);
        add_sample(8'h55, 8'h6a, 8'h7f, 8'h7f);
        add_sample(8'h00, 8'h80, 8'h80, 8'h80);
        for (n = 0; n < 7; n++)
            add_poll();
        add_sample(8'hff, 8'h3f, 8'h00, 8'h00);
        add_poll();

        // random mix: frequent polls keep the fifo shallow so it empties often
        keep_a = 8'h00;
        keep_b = 8'h00;
        for (n = 0; n < 1480; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                add_poll(n == 740);
            end else begin
                if (roll < 55) begin
                    // same buttons again: zero release, often a skipped repeat
                end else if (roll < 62) begin
                    keep_a = 8'hff;
                    keep_b = 8'hff;
                end else if (roll < 68) begin
                    keep_a = 8'h00;
                    keep_b = 8'($urandom) & 8'hc0;
                end else begin
                    keep_a = 8'($urandom);
                    keep_b = 8'($urandom);
                end
                add_sample(keep_a, keep_b, pick_stick(), pick_stick(), n == 740);
            end
        end

        // short random tail
        for (n = 0; n < 150; n++) begin
            if ($urandom_range(0, 1) == 0)
                add_poll();
            else
                add_sample(8'($urandom), 8'($urandom), pick_stick(), pick_stick());
        end

        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || in_valid)
            @(posedge clk);
        while (polls_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        if (polls_due.size() != 0)
            log_failure($sformatf("%0d polls never answered", polls_due.size()));
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
